@@ hdl/ldc_pkg.sv @@
package ldc_pkg;

  localparam int WORD_BITS = 48;
  localparam int CNT_W     = $clog2(WORD_BITS);
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CLK_W     = 6;
  localparam int LEN_W     = 9;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [1:0] CMD_GS         = 2'd0;
  localparam logic [1:0] CMD_FC         = 2'd1;
  localparam logic [1:0] CMD_FRAME_SYNC = 2'd2;
  localparam logic [1:0] CMD_FCWREN     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GS_CLOCKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FC_CLOCKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VSYNC_CLOCKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FCWREN_CLOCKS = 3'd4;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(WORD_BITS - 1);

  typedef struct packed {
    logic [1:0]           command;
    logic [WORD_BITS-1:0] word;
  } ldc_req_t;

  typedef struct packed {
    logic data_bit;
    logic latch_level;
    logic last_bit;
  } ldc_res_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [CNT_W-1:0]     start;
    logic [CNT_W-1:0]     k;
  } ldc_desc_t;

  function automatic logic [CNT_W-1:0] clamp_clocks(input logic [CLK_W-1:0] k);
    logic [CNT_W-1:0] r;
    if (k > CLK_W'(WORD_BITS - 1)) begin
      r = LAST_IDX;
    end else begin
      r = CNT_W'(k);
    end
    return r;
  endfunction

endpackage

@@ hdl/ldc_front.sv @@
module ldc_front import ldc_pkg::*; #(
  parameter int MAX_CHIPS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 accept_i,
  input  ldc_req_t             req_i,
  output logic                 push_o,
  output ldc_desc_t            desc_o
);

  localparam int WS_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

  logic [CFG_W-1:0] chain_q;
  logic [CLK_W-1:0] gs_q, fc_q, vs_q, we_q;
  logic [WS_W-1:0]  ws_q, ws_d;
  logic [LEN_W-1:0] len_eff, ws_next;
  logic             last_word, is_cmd;
  logic [CNT_W-1:0] k_cmd, k_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= CFG_W'(1);
      gs_q    <= CLK_W'(1);
      fc_q    <= CLK_W'(5);
      vs_q    <= CLK_W'(3);
      we_q    <= CLK_W'(15);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CHAIN_LENGTH:  chain_q <= cfg_wdata_i;
        REG_GS_CLOCKS:     gs_q    <= cfg_wdata_i[CLK_W-1:0];
        REG_FC_CLOCKS:     fc_q    <= cfg_wdata_i[CLK_W-1:0];
        REG_VSYNC_CLOCKS:  vs_q    <= cfg_wdata_i[CLK_W-1:0];
        REG_FCWREN_CLOCKS: we_q    <= cfg_wdata_i[CLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (chain_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(chain_q) > LEN_W'(MAX_CHIPS)) begin
      len_eff = LEN_W'(MAX_CHIPS);
    end else begin
      len_eff = LEN_W'(chain_q);
    end
    ws_next   = LEN_W'(ws_q) + LEN_W'(1);
    last_word = ws_next >= len_eff;
    is_cmd    = (req_i.command == CMD_FRAME_SYNC) || (req_i.command == CMD_FCWREN);
    k_cmd     = clamp_clocks((req_i.command == CMD_FRAME_SYNC) ? vs_q : we_q);
    k_data    = last_word ?
                clamp_clocks((req_i.command == CMD_GS) ? gs_q : fc_q) : '0;

    ws_d = ws_q;
    if (accept_i && !is_cmd) begin
      ws_d = last_word ? '0 : ws_next[WS_W-1:0];
    end

    if (is_cmd) begin
      desc_o.word  = '0;
      desc_o.start = k_cmd - CNT_W'(1);
      desc_o.k     = k_cmd;
      push_o       = accept_i && (k_cmd != '0);
    end else begin
      desc_o.word  = req_i.word;
      desc_o.start = LAST_IDX;
      desc_o.k     = k_data;
      push_o       = accept_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= '0;
    end else begin
      ws_q <= ws_d;
    end
  end

endmodule

@@ hdl/ldc_fifo.sv @@
module ldc_fifo import ldc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ldc_desc_t wdata_i,
  input  logic      pop_i,
  output ldc_desc_t rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  ldc_desc_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QPTR_W:0]     cnt_q;

  assign full_o  = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hdl/ldc_back.sv @@
module ldc_back import ldc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  ldc_desc_t desc_i,
  output logic      q_pop_o,
  output logic      busy_o,
  output logic      empty_o,
  output ldc_res_t  res_o,
  input  logic      pop_i
);

  logic [WORD_BITS-1:0] sh_q;
  logic [CNT_W-1:0]     cnt_q, k_q;
  logic                 busy_q, out_valid_q;
  ldc_res_t             out_q;
  logic                 can_load, emit, finish;

  assign can_load = !out_valid_q || pop_i;
  assign emit     = busy_q && can_load;
  assign finish   = emit && (cnt_q == '0);
  assign q_pop_o  = !q_empty_i && (!busy_q || finish);
  assign busy_o   = busy_q;
  assign empty_o  = !out_valid_q;
  assign res_o    = out_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      sh_q  <= desc_i.word;
      cnt_q <= desc_i.start;
      k_q   <= desc_i.k;
    end else if (emit) begin
      sh_q  <= {sh_q[WORD_BITS-2:0], 1'b0};
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (emit) begin
      out_q.data_bit    <= sh_q[WORD_BITS-1];
      out_q.latch_level <= cnt_q < k_q;
      out_q.last_bit    <= cnt_q == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/led_driver_latch_command_shifter_top.sv @@
// Serial shifter for a daisy chain of LED drivers that take a command as the
// number of clocks spent with the latch line high.
// Request side: push_i with in_i (command, word); a request is taken when
// push_i is high and full_o low. Result side: one result per serial clock
// (data_bit, latch_level, last_bit) is on res_o while empty_o is low and is
// taken when pop_i is high.
// A data word yields 48 results, MSB first; the last word of the chain
// raises the latch on its final k results. Vsync and write enable yield k
// zero bits with the latch high, or nothing when k is zero.
// A taken request passes through the queue, the shifter registers and the
// output register before its first result appears. Throughput: one result
// per cycle while the receiver keeps pop_i high; the single-bit shifter
// sets that rate. A two-entry queue sits between the classifier and the
// shifter, so requests are taken while a word is shifting.
// Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i, taken at once.
// Reset: queue and output empty, word count zero, registers at defaults.
// A stalled receiver holds the current result; the queue then fills and
// full_o rises.
module led_driver_latch_command_shifter_top import ldc_pkg::*; #(
  parameter int MAX_CHIPS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 push_i,
  output logic                 full_o,
  input  ldc_req_t             in_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output ldc_res_t             res_o
);

  logic      accept, f_push, q_pop, q_empty, busy;
  ldc_desc_t f_desc, q_desc;

  assign accept = push_i && !full_o;

  ldc_front #(.MAX_CHIPS(MAX_CHIPS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .req_i      (in_i),
    .push_o     (f_push),
    .desc_o     (f_desc)
  );

  ldc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .wdata_i(f_desc),
    .pop_i  (q_pop),
    .rdata_o(q_desc),
    .full_o (full_o),
    .empty_o(q_empty)
  );

  ldc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .desc_i   (q_desc),
    .q_pop_o  (q_pop),
    .busy_o   (busy),
    .empty_o  (empty_o),
    .res_o    (res_o),
    .pop_i    (pop_i)
  );

  a_reset_empty : assert property (@(posedge clk_i) !rst_ni |=> empty_o)
    else $error("result queue not empty after reset");

  a_full_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> busy)
    else $error("queue full while shifter idle");

  a_mid_item_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !res_o.last_bit) |-> busy)
    else $error("item ended without a final clock");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import ldc_pkg::*;

  localparam int CHAIN_MAX = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REQUESTS = 25;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic push_i = 1'b0;
  logic full_o;
  ldc_req_t in_i = '0;
  logic empty_o;
  logic pop_i = 1'b0;
  ldc_res_t res_o;

  led_driver_latch_command_shifter_top #(.MAX_CHIPS(CHAIN_MAX)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i(push_i),
    .full_o(full_o),
    .in_i(in_i),
    .empty_o(empty_o),
    .pop_i(pop_i),
    .res_o(res_o)
  );

  always #1 clk_i = ~clk_i;

  logic [6:0] chain_len = 7'd1;
  logic [CLK_W-1:0] gs_clocks = 6'd1;
  logic [CLK_W-1:0] fc_clocks = 6'd5;
  logic [CLK_W-1:0] vsync_clocks = 6'd3;
  logic [CLK_W-1:0] fcwren_clocks = 6'd15;
  logic [5:0] chip_words = '0;

  ldc_req_t request_q[$];
  ldc_res_t expected_bits[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit gap_on = 1'b0;
  bit stall_on = 1'b0;
  int unsigned gap_cnt = 0;
  int unsigned stall_cnt = 0;

  function automatic int unsigned sat_clocks(input logic [CLK_W-1:0] k);
    if (int'(k) > WORD_BITS - 1) return WORD_BITS - 1;
    return int'(k);
  endfunction

  function automatic int unsigned chain_words();
    if (chain_len == 0) return 1;
    if (int'(chain_len) > CHAIN_MAX) return CHAIN_MAX;
    return int'(chain_len);
  endfunction

  function automatic void predict_serial_bits(input ldc_req_t req);
    int unsigned k;
    bit end_of_chain;
    ldc_res_t r;
    if (req.command == CMD_FRAME_SYNC || req.command == CMD_FCWREN) begin
      k = sat_clocks(req.command == CMD_FRAME_SYNC ? vsync_clocks : fcwren_clocks);
      for (int unsigned i = 0; i < k; i++) begin
        r.data_bit = 1'b0;
        r.latch_level = 1'b1;
        r.last_bit = (i + 1 == k);
        expected_bits.push_back(r);
      end
    end else begin
      end_of_chain = (int'(chip_words) + 1 >= chain_words());
      k = end_of_chain ? sat_clocks(req.command == CMD_GS ? gs_clocks : fc_clocks) : 0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
        r.data_bit = req.word[i];
        r.latch_level = (i < int'(k));
        r.last_bit = (i == 0);
        expected_bits.push_back(r);
      end
      chip_words = end_of_chain ? 6'd0 : chip_words + 6'd1;
    end
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[WORD_BITS-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] rand_clocks();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd47;
      3: return 7'($urandom_range(48, 127));
      default: return 7'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic void queue_request(input logic [1:0] cmd, input logic [WORD_BITS-1:0] w);
    ldc_req_t req;
    req.command = cmd;
    req.word = w;
    request_q.push_back(req);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CHAIN_LENGTH: chain_len = val;
      REG_GS_CLOCKS: gs_clocks = val[CLK_W-1:0];
      REG_FC_CLOCKS: fc_clocks = val[CLK_W-1:0];
      REG_VSYNC_CLOCKS: vsync_clocks = val[CLK_W-1:0];
      REG_FCWREN_CLOCKS: fcwren_clocks = val[CLK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] gs,
                           input logic [CFG_W-1:0] fc, input logic [CFG_W-1:0] vs,
                           input logic [CFG_W-1:0] we);
    write_reg(REG_CHAIN_LENGTH, len);
    write_reg(REG_GS_CLOCKS, gs);
    write_reg(REG_FC_CLOCKS, fc);
    write_reg(REG_VSYNC_CLOCKS, vs);
    write_reg(REG_FCWREN_CLOCKS, we);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (request_q.size() != 0 || push_i || expected_bits.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("led_driver_latch_command_shifter_top verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push_i <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (push_i && !full_o) predict_serial_bits(in_i);
      if (!push_i || !full_o) begin
        if (gap_cnt != 0) begin
          push_i <= 1'b0;
          gap_cnt <= gap_cnt - 1;
        end else if (request_q.size() != 0) begin
          in_i <= request_q.pop_front();
          push_i <= 1'b1;
          gap_cnt <= gap_on ? $urandom_range(0, 8) : 0;
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    ldc_res_t exp_bit;
    int unsigned s;
    if (!rst_ni) begin
      pop_i <= 1'b0;
      stall_cnt <= 0;
    end else if (pop_i && !empty_o) begin
      if (expected_bits.size() == 0) begin
        $error("unexpected result %b", res_o);
        fail_count++;
      end else begin
        exp_bit = expected_bits.pop_front();
        if (res_o.data_bit !== exp_bit.data_bit) begin
          $error("data_bit expected %b actual %b", exp_bit.data_bit, res_o.data_bit);
          fail_count++;
        end
        if (res_o.latch_level !== exp_bit.latch_level) begin
          $error("latch_level expected %b actual %b", exp_bit.latch_level, res_o.latch_level);
          fail_count++;
        end
        if (res_o.last_bit !== exp_bit.last_bit) begin
          $error("last_bit expected %b actual %b", exp_bit.last_bit, res_o.last_bit);
          fail_count++;
        end
      end
      s = stall_on ? $urandom_range(0, 8) : 0;
      stall_cnt <= s;
      pop_i <= (s == 0);
    end else if (!pop_i) begin
      if (stall_cnt <= 1) begin
        pop_i <= 1'b1;
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned frame;
    logic [1:0] cmd;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_on = 1'b0;
    stall_on = 1'b0;
    queue_request(CMD_GS, {WORD_BITS{1'b1}});
    queue_request(CMD_GS, '0);
    queue_request(CMD_FC, 48'hAAAA_AAAA_AAAA);
    queue_request(CMD_FC, 48'h5555_5555_5555);
    queue_request(CMD_FRAME_SYNC, {WORD_BITS{1'b1}});
    queue_request(CMD_FCWREN, rand_word());
    drain();

    gap_on = 1'b1;
    stall_on = 1'b1;
    write_all(7'd3, 7'd47, 7'd63, 7'd0, 7'd47);
    queue_request(CMD_GS, {WORD_BITS{1'b1}});
    queue_request(CMD_GS, rand_word());
    queue_request(CMD_GS, {WORD_BITS{1'b1}});
    queue_request(CMD_FCWREN, rand_word());
    queue_request(CMD_FC, rand_word());
    queue_request(CMD_FC, rand_word());
    queue_request(CMD_FC, {WORD_BITS{1'b1}});
    queue_request(CMD_FRAME_SYNC, rand_word());
    drain();

    write_all(7'd0, 7'd0, 7'd48, 7'd127, 7'd1);
    write_reg(REG_UNUSED, 7'h7F);
    queue_request(CMD_GS, {WORD_BITS{1'b1}});
    queue_request(CMD_FC, {WORD_BITS{1'b1}});
    queue_request(CMD_FRAME_SYNC, '0);
    queue_request(CMD_FCWREN, '0);
    queue_request(CMD_GS, rand_word());
    drain();

    write_all(7'd127, 7'd1, 7'd2, 7'd3, 7'd4);
    queue_request(CMD_GS, rand_word());
    queue_request(CMD_FC, rand_word());
    queue_request(CMD_GS, rand_word());
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gap_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: write_reg(REG_CHAIN_LENGTH, 7'd0);
        1: write_reg(REG_CHAIN_LENGTH, 7'($urandom_range(64, 127)));
        default: write_reg(REG_CHAIN_LENGTH, 7'($urandom_range(1, 5)));
      endcase
      write_reg(REG_GS_CLOCKS, rand_clocks());
      write_reg(REG_FC_CLOCKS, rand_clocks());
      write_reg(REG_VSYNC_CLOCKS, rand_clocks());
      write_reg(REG_FCWREN_CLOCKS, rand_clocks());
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        if ($urandom_range(0, 9) < 7) begin
          cmd = $urandom_range(0, 1) ? CMD_FC : CMD_GS;
          frame = (chain_words() <= 8) ? chain_words() : $urandom_range(1, 8);
          if ($urandom_range(0, 4) == 0) frame = $urandom_range(1, frame);
          if (cmd == CMD_FC) begin
            queue_request(CMD_FCWREN, rand_word());
            sent++;
          end
          for (int unsigned i = 0; i < frame; i++) begin
            queue_request(cmd, rand_word());
            sent++;
          end
          if (cmd == CMD_GS && $urandom_range(0, 2) != 0) begin
            queue_request(CMD_FRAME_SYNC, rand_word());
            sent++;
          end
        end else begin
          queue_request(2'($urandom_range(0, 3)), rand_word());
          sent++;
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    if (fail_count == 0 && expected_bits.size() == 0) begin
      $display("led_driver_latch_command_shifter_top verification clean");
    end else begin
      $display("led_driver_latch_command_shifter_top verification failed");
    end
    $finish;
  end

endmodule
